>>> hw/rtl/cdq_pkg.sv
package cdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int ACTION_W  = 2;
    localparam int OUT_W     = 2 * VALUE_W + COUNT_W + 3;

    localparam logic [VALUE_W-1:0] EMPTY_VALUE = '1;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT = 2'd0,
        ACT_PUSH_REAR  = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_TAKE_LOWER = 2'd1,
        CELL_TAKE_UPPER = 2'd2,
        CELL_LOAD       = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage

>>> hw/rtl/circular_deque_core.sv
// a result is registered and appears in the cycle after its item is accepted
// throughput: one item per cycle unless the output stalls; the rear read is a select over the cell row
// front stays in cell 0, the row shifts as a whole on a push or pop at the front
// reset: synchronous, active low; clears the count and the output valid
// cell contents are not reset and are never shown before written
module circular_deque_core
    import cdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [VALUE_W-1:0]  i_s_axis_tdata,  // value
    input  logic [ACTION_W-1:0] i_s_axis_tuser,  // action
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // front_value, rear_value, item_count, is_empty, is_full, refused
    output logic [OUT_W-1:0]    o_m_axis_tdata
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [VALUE_W-1:0] w_cell [DEPTH];
    t_cell_ctl          w_ctl  [DEPTH];

    logic [CW-1:0]      r_count;
    logic [CW-1:0]      n_count;
    logic               r_m_valid;
    logic [OUT_W-1:0]   r_m_data;
    logic [OUT_W-1:0]   n_m_data;

    logic               w_accept;
    t_action            w_action;
    logic               w_full;
    logic               w_empty;
    logic               w_push_front;
    logic               w_push_rear;
    logic               w_pop_front;
    logic               w_pop_rear;
    logic               w_refused;
    logic [IW-1:0]      w_rear_idx;
    logic [VALUE_W-1:0] w_front;
    logic [VALUE_W-1:0] w_rear;

    assign o_s_axis_tready = !r_m_valid || i_m_axis_tready;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_action        = t_action'(i_s_axis_tuser);
    assign w_full          = (r_count == CW'(DEPTH));
    assign w_empty         = (r_count == '0);

    always_comb begin
        w_push_front = 1'b0;
        w_push_rear  = 1'b0;
        w_pop_front  = 1'b0;
        w_pop_rear   = 1'b0;
        w_refused    = 1'b0;
        unique case (w_action)
            ACT_PUSH_FRONT: begin
                w_push_front = !w_full;
                w_refused    = w_full;
            end
            ACT_PUSH_REAR: begin
                w_push_rear = !w_full;
                w_refused   = w_full;
            end
            ACT_POP_FRONT: begin
                w_pop_front = !w_empty;
                w_refused   = w_empty;
            end
            ACT_POP_REAR: begin
                w_pop_rear = !w_empty;
                w_refused  = w_empty;
            end
            default: begin
                w_refused = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        if (w_push_front || w_push_rear) begin
            n_count = r_count + CW'(1);
        end else if (w_pop_front || w_pop_rear) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].op = CELL_HOLD;
            if (w_accept) begin
                if (w_push_front) begin
                    w_ctl[i].op = CELL_TAKE_LOWER;
                end else if (w_pop_front) begin
                    w_ctl[i].op = CELL_TAKE_UPPER;
                end else if (w_push_rear && (CW'(i) == r_count)) begin
                    w_ctl[i].op = CELL_LOAD;
                end
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [VALUE_W-1:0] w_lower;
            logic [VALUE_W-1:0] w_upper;
            if (g == 0) begin : g_first
                assign w_lower = i_s_axis_tdata;
            end else begin : g_mid_lo
                assign w_lower = w_cell[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_upper = w_cell[g];
            end else begin : g_mid_hi
                assign w_upper = w_cell[g+1];
            end
            cdq_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_ctl[g]),
                .i_lower (w_lower),
                .i_upper (w_upper),
                .i_value (i_s_axis_tdata),
                .o_data  (w_cell[g])
            );
        end
    endgenerate

    // rear after a rear pop is the second last element
    assign w_rear_idx = w_pop_rear ? IW'(r_count - CW'(2)) : IW'(r_count - CW'(1));

    always_comb begin
        if (w_push_front || w_push_rear) begin
            w_front = w_push_front || w_empty ? i_s_axis_tdata : w_cell[0];
        end else if (w_pop_front) begin
            w_front = w_cell[1];
        end else begin
            w_front = w_cell[0];
        end

        if (w_push_rear || (w_push_front && w_empty)) begin
            w_rear = i_s_axis_tdata;
        end else begin
            w_rear = w_cell[w_rear_idx];
        end

        if (n_count == '0) begin
            w_front = EMPTY_VALUE;
            w_rear  = EMPTY_VALUE;
        end
    end

    assign n_m_data = {w_refused,
                       (n_count == CW'(DEPTH)),
                       (n_count == '0),
                       COUNT_W'(n_count),
                       w_rear,
                       w_front};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

>>> hw/rtl/cdq_cell.sv
module cdq_cell
    import cdq_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctl          i_ctl,
    input  logic [VALUE_W-1:0] i_lower,
    input  logic [VALUE_W-1:0] i_upper,
    input  logic [VALUE_W-1:0] i_value,
    output logic [VALUE_W-1:0] o_data
);

    logic [VALUE_W-1:0] r_data;
    logic [VALUE_W-1:0] n_data;

    always_comb begin
        case (i_ctl.op)
            CELL_TAKE_LOWER: n_data = i_lower;
            CELL_TAKE_UPPER: n_data = i_upper;
            CELL_LOAD:       n_data = i_value;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
